### hw/rtl/mal_pkg.sv
// mal_pkg: shared types, constants and helpers of the multitrack audio looper
// depends on nothing

package mal_pkg;

    localparam int TRACK_COUNT_DEF     = 4;
    localparam int CHUNK_LEN_DEF       = 64;
    localparam int MAX_LOOP_CHUNKS_DEF = 256;

    localparam logic [31:0] FRAME_MASK = 32'hF000_000F;
    localparam logic [31:0] AUDIO_MASK = 32'h0FFF_FFF0;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_CTRL   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        TS_IDLE = 2'd0,
        TS_REC  = 2'd1,
        TS_DUB  = 2'd2,
        TS_MON  = 2'd3
    } track_state_t;

    typedef enum logic [1:0] {
        K_SAMPLE = 2'd0,
        K_CTRL   = 2'd1,
        K_CLEAR  = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t   kind;
        logic [31:0]  sample_word;
        logic [1:0]   track_select;
        track_state_t track_mode;
        logic         track_muted;
        logic [7:0]   record_offset;
        logic [8:0]   recorded_length;
    } mal_item_t;

    // 24-bit audio add with wrap, framing nibbles of acc kept
    function automatic logic [31:0] audio_add(input logic [31:0] acc, input logic [31:0] w);
        logic [31:0] s;
        s = (acc & AUDIO_MASK) + (w & AUDIO_MASK);
        return (acc & FRAME_MASK) | (s & AUDIO_MASK);
    endfunction

endpackage

### hw/rtl/mal_if.sv
// mal_if: valid/ready channel interfaces for input items and mixed results
// depends on nothing

interface mal_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] sample_word;
    logic [1:0]  track_select;
    logic [1:0]  track_mode;
    logic        track_muted;
    logic [7:0]  record_offset;
    logic [8:0]  recorded_length;

    modport source (
        output valid, opcode, sample_word, track_select, track_mode, track_muted,
               record_offset, recorded_length,
        input  ready
    );
    modport sink (
        input  valid, opcode, sample_word, track_select, track_mode, track_muted,
               record_offset, recorded_length,
        output ready
    );
endinterface

interface mal_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mixed_word;
    logic        chunk_end;

    modport source (output valid, mixed_word, chunk_end, input ready);
    modport sink (input valid, mixed_word, chunk_end, output ready);
endinterface

### hw/rtl/mal_front.sv
// mal_front: accepts input items, classifies them and queues them for the back end
// depends on mal_pkg

module mal_front
    import mal_pkg::*;
#(
    parameter int TRACK_COUNT = TRACK_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] sample_word,
    input  logic [1:0]  track_select,
    input  logic [1:0]  track_mode,
    input  logic        track_muted,
    input  logic [7:0]  record_offset,
    input  logic [8:0]  recorded_length,
    output logic        q_valid,
    output mal_item_t   q_item,
    input  logic        q_pop
);

    mal_item_t  fifo_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    mal_item_t  item;
    logic       keep;
    logic       push;

    always_comb
    begin
        item.sample_word     = sample_word;
        item.track_select    = track_select;
        item.track_mode      = track_state_t'(track_mode);
        item.track_muted     = track_muted;
        item.record_offset   = record_offset;
        item.recorded_length = recorded_length;
        item.kind            = K_SAMPLE;
        keep                 = 1'b0;
        case (opcode_t'(opcode))
            OP_SAMPLE:
            begin
                item.kind = K_SAMPLE;
                keep      = 1'b1;
            end
            OP_CTRL:
            begin
                item.kind = K_CTRL;
                // commands for tracks that do not exist are dropped here
                keep      = (int'(track_select) < TRACK_COUNT);
            end
            OP_CLEAR:
            begin
                item.kind = K_CLEAR;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

### hw/rtl/mal_back.sv
// mal_back: track state, loop memory and the per-sample track sequencer
// depends on mal_pkg

module mal_back
    import mal_pkg::*;
#(
    parameter int TRACK_COUNT     = TRACK_COUNT_DEF,
    parameter int CHUNK_LEN       = CHUNK_LEN_DEF,
    parameter int MAX_LOOP_CHUNKS = MAX_LOOP_CHUNKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  mal_item_t   q_item,
    output logic        q_pop,
    input  logic        shared_off,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] mixed_word,
    output logic        chunk_end
);

    localparam int PW        = $clog2(MAX_LOOP_CHUNKS + 1);
    // global position runs below the global length, which can reach the full memory length
    localparam int GPW       = PW;
    localparam int TW        = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int SCW       = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
    localparam int POSW      = (PW > 10) ? PW : 10;
    localparam int SW        = POSW + 1;
    localparam int MEM_DEPTH = TRACK_COUNT * MAX_LOOP_CHUNKS * CHUNK_LEN;
    localparam int AW        = $clog2(MEM_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOD,
        S_DATA,
        S_END,
        S_ADV,
        S_WRAP
    } fsm_t;

    fsm_t          fsm_reg;
    track_state_t  st_reg   [TRACK_COUNT];
    logic          mute_reg [TRACK_COUNT];
    logic [PW-1:0] pos_reg  [TRACK_COUNT];
    logic [PW-1:0] len_reg  [TRACK_COUNT];
    logic [7:0]    off_reg  [TRACK_COUNT];
    logic [8:0]    rlen_reg [TRACK_COUNT];
    logic [PW-1:0] gl_reg;
    logic [GPW-1:0] gp_reg;
    logic [SCW-1:0] sic_reg;

    logic [TW-1:0]   t_reg;
    logic [31:0]     word_reg;
    logic [POSW-1:0] cur_pos_reg;
    logic [31:0]     mix_reg;
    logic            any_reg;
    logic            via_reg;
    logic [31:0]     rdata_reg;
    logic            out_valid_reg;
    logic [31:0]     mixed_word_reg;
    logic            chunk_end_reg;

    logic [31:0] mem [MEM_DEPTH];

    track_state_t    cur_st;
    logic [SW-1:0]   sync_sum;
    logic [POSW-1:0] sync_pos;
    logic [POSW-1:0] read_pos;
    logic            in_region;
    logic            last_track;
    logic [AW-1:0]   mem_addr;
    logic            mem_we;
    logic            mem_re;
    logic [31:0]     mem_wdata;
    logic            contrib;
    logic [31:0]     contrib_w;
    logic [31:0]     mix_final;
    logic [PW:0]     p1;
    logic            sic_last;
    logic [TW-1:0]   sel;

    assign cur_st     = st_reg[t_reg];
    assign last_track = (t_reg == TW'(TRACK_COUNT - 1));
    assign sel        = TW'(q_item.track_select);
    assign sic_last   = (sic_reg == SCW'(CHUNK_LEN - 1));
    assign p1         = {1'b0, pos_reg[t_reg]} + (PW + 1)'(1);

    // position on the shared timeline, taken mod 1024 then folded once
    always_comb
    begin
        sync_sum = SW'(gp_reg) + SW'(gl_reg) - SW'(off_reg[t_reg]);
        sync_pos = POSW'(sync_sum[9:0]);
        if (sync_pos >= POSW'(gl_reg))
        begin
            sync_pos = sync_pos - POSW'(gl_reg);
        end
        if (shared_off || (gl_reg == '0))
        begin
            read_pos = POSW'(pos_reg[t_reg]);
        end
        else
        begin
            read_pos = sync_pos;
        end
        in_region = (rlen_reg[t_reg] == 9'd0) || (read_pos < POSW'(rlen_reg[t_reg]));
    end

    assign mem_addr = (AW'(t_reg) * AW'(MAX_LOOP_CHUNKS) + AW'(cur_pos_reg)) * AW'(CHUNK_LEN)
                      + AW'(sic_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = word_reg;
        contrib   = 1'b0;
        contrib_w = word_reg;
        if (fsm_reg == S_MOD && cur_pos_reg < POSW'(MAX_LOOP_CHUNKS))
        begin
            if (cur_st == TS_REC)
            begin
                mem_we  = 1'b1;
                contrib = 1'b1;
            end
            else
            begin
                mem_re = 1'b1;
            end
        end
        else if (fsm_reg == S_DATA)
        begin
            contrib = 1'b1;
            if (cur_st == TS_DUB)
            begin
                contrib_w = audio_add(rdata_reg, word_reg);
                mem_wdata = contrib_w;
                mem_we    = 1'b1;
            end
            else
            begin
                contrib_w = rdata_reg;
            end
        end
        if (!any_reg)
        begin
            mix_final = word_reg;
        end
        else if (!via_reg)
        begin
            mix_final = audio_add(mix_reg, word_reg);
        end
        else
        begin
            mix_final = mix_reg;
        end
    end

    assign q_pop = (fsm_reg == S_IDLE) && q_valid;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            word_reg <= q_item.sample_word;
        end
        if (contrib)
        begin
            if (!any_reg)
            begin
                mix_reg <= mute_reg[t_reg] ? (contrib_w & FRAME_MASK) : contrib_w;
            end
            else if (!mute_reg[t_reg])
            begin
                mix_reg <= audio_add(mix_reg, contrib_w);
            end
        end
        if (fsm_reg == S_SCAN)
        begin
            cur_pos_reg <= (cur_st == TS_REC) ? POSW'(pos_reg[t_reg]) : read_pos;
        end
        else if (fsm_reg == S_MOD && cur_pos_reg >= POSW'(MAX_LOOP_CHUNKS))
        begin
            cur_pos_reg <= cur_pos_reg - POSW'(MAX_LOOP_CHUNKS);
        end
        else if (fsm_reg == S_ADV)
        begin
            cur_pos_reg <= POSW'(p1);
        end
        else if (fsm_reg == S_WRAP && cur_pos_reg >= POSW'(len_reg[t_reg]))
        begin
            cur_pos_reg <= cur_pos_reg - POSW'(len_reg[t_reg]);
        end
        if (fsm_reg == S_END && (!out_valid_reg || out_ready))
        begin
            mixed_word_reg <= mix_final;
            chunk_end_reg  <= sic_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            t_reg         <= '0;
            any_reg       <= 1'b0;
            via_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            gl_reg        <= '0;
            gp_reg        <= '0;
            sic_reg       <= '0;
            for (int i = 0; i < TRACK_COUNT; i++)
            begin
                st_reg[i]   <= TS_IDLE;
                mute_reg[i] <= 1'b0;
                pos_reg[i]  <= '0;
                len_reg[i]  <= '0;
                off_reg[i]  <= '0;
                rlen_reg[i] <= '0;
            end
        end
        else
        begin
            if (fsm_reg == S_END && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (contrib)
            begin
                any_reg <= 1'b1;
            end
            case (fsm_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        case (q_item.kind)
                            K_SAMPLE:
                            begin
                                t_reg   <= '0;
                                any_reg <= 1'b0;
                                via_reg <= 1'b0;
                                fsm_reg <= S_SCAN;
                            end
                            K_CTRL:
                            begin
                                st_reg[sel]   <= q_item.track_mode;
                                mute_reg[sel] <= q_item.track_muted;
                                off_reg[sel]  <= q_item.record_offset;
                                rlen_reg[sel] <= q_item.recorded_length;
                            end
                            K_CLEAR:
                            begin
                                gl_reg  <= '0;
                                gp_reg  <= '0;
                                sic_reg <= '0;
                                for (int i = 0; i < TRACK_COUNT; i++)
                                begin
                                    st_reg[i]   <= TS_IDLE;
                                    pos_reg[i]  <= '0;
                                    len_reg[i]  <= '0;
                                    off_reg[i]  <= '0;
                                    rlen_reg[i] <= '0;
                                end
                            end
                            default:
                            begin
                                fsm_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (cur_st == TS_REC || cur_st == TS_DUB)
                    begin
                        via_reg <= 1'b1;
                    end
                    if (cur_st == TS_REC || (cur_st != TS_IDLE && in_region))
                    begin
                        fsm_reg <= S_MOD;
                    end
                    else if (last_track)
                    begin
                        fsm_reg <= S_END;
                    end
                    else
                    begin
                        t_reg <= t_reg + TW'(1);
                    end
                end
                S_MOD:
                begin
                    // positions past the memory wrap, one subtract per cycle
                    if (cur_pos_reg < POSW'(MAX_LOOP_CHUNKS))
                    begin
                        if (cur_st != TS_REC)
                        begin
                            fsm_reg <= S_DATA;
                        end
                        else if (last_track)
                        begin
                            fsm_reg <= S_END;
                        end
                        else
                        begin
                            t_reg   <= t_reg + TW'(1);
                            fsm_reg <= S_SCAN;
                        end
                    end
                end
                S_DATA:
                begin
                    if (last_track)
                    begin
                        fsm_reg <= S_END;
                    end
                    else
                    begin
                        t_reg   <= t_reg + TW'(1);
                        fsm_reg <= S_SCAN;
                    end
                end
                S_END:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        if (sic_last)
                        begin
                            sic_reg <= '0;
                            t_reg   <= '0;
                            fsm_reg <= S_ADV;
                            if (!shared_off && gl_reg != '0)
                            begin
                                if (PW'(gp_reg) + PW'(1) == gl_reg)
                                begin
                                    gp_reg <= '0;
                                end
                                else
                                begin
                                    gp_reg <= gp_reg + GPW'(1);
                                end
                            end
                        end
                        else
                        begin
                            sic_reg <= sic_reg + SCW'(1);
                            fsm_reg <= S_IDLE;
                        end
                    end
                end
                S_ADV:
                begin
                    if (cur_st == TS_REC)
                    begin
                        pos_reg[t_reg] <= PW'(p1);
                        if (!shared_off && gl_reg != '0 && p1 >= (PW + 1)'(gl_reg))
                        begin
                            len_reg[t_reg] <= gl_reg;
                            st_reg[t_reg]  <= TS_DUB;
                        end
                        else
                        begin
                            len_reg[t_reg] <= PW'(p1);
                            if (p1 >= (PW + 1)'(MAX_LOOP_CHUNKS))
                            begin
                                if (!shared_off && gl_reg == '0)
                                begin
                                    gl_reg <= PW'(p1);
                                    gp_reg <= '0;
                                end
                                st_reg[t_reg] <= TS_DUB;
                            end
                        end
                    end
                    if (shared_off && (cur_st == TS_DUB || cur_st == TS_MON)
                        && len_reg[t_reg] != '0)
                    begin
                        // free-running loop, position folded back in S_WRAP
                        fsm_reg <= S_WRAP;
                    end
                    else if (last_track)
                    begin
                        fsm_reg <= S_IDLE;
                    end
                    else
                    begin
                        t_reg <= t_reg + TW'(1);
                    end
                end
                S_WRAP:
                begin
                    // one subtract of the loop length per cycle
                    if (cur_pos_reg < POSW'(len_reg[t_reg]))
                    begin
                        pos_reg[t_reg] <= PW'(cur_pos_reg);
                        if (last_track)
                        begin
                            fsm_reg <= S_IDLE;
                        end
                        else
                        begin
                            t_reg   <= t_reg + TW'(1);
                            fsm_reg <= S_ADV;
                        end
                    end
                end
                default:
                begin
                    fsm_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign mixed_word = mixed_word_reg;
    assign chunk_end  = chunk_end_reg;

endmodule

### hw/rtl/multitrack_audio_looper.sv
// multitrack_audio_looper: top level, APB config register, front end, queue and back end
// depends on mal_pkg, mal_if, mal_front, mal_back
//
//  channel   dir  handshake        carries
//  in_ch     in   valid/ready      opcode, sample_word, track controls
//  out_ch    out  valid/ready      mixed_word, chunk_end
//  apb       in   psel/penable     shared_timeline_off at address 0
//
// a sample takes a pop step, per track a scan step when skipped, scan and memory steps
// when recording, scan, memory and data steps when read (plus a memory step per wrap of
// a position past the memory), and an output step that waits while the previous result
// is not taken; the single-port loop memory sets this
// the last sample of a chunk adds a position-advance step per track, plus for each
// free-running dub or monitor track a wrap step and one more per loop length folded away
// commands apply from the idle state; a two-entry queue accepts while the back end works
// reset is asynchronous; loop memory is not cleared

module multitrack_audio_looper
    import mal_pkg::*;
#(
    parameter int TRACK_COUNT     = TRACK_COUNT_DEF,
    parameter int CHUNK_LEN       = CHUNK_LEN_DEF,
    parameter int MAX_LOOP_CHUNKS = MAX_LOOP_CHUNKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mal_in_if.sink      in_ch,
    mal_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic      shared_timeline_off_reg;
    logic      q_valid;
    mal_item_t q_item;
    logic      q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {31'd0, shared_timeline_off_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shared_timeline_off_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr == 3'd0)
        begin
            shared_timeline_off_reg <= pwdata[0];
        end
    end

    mal_front #(
        .TRACK_COUNT (TRACK_COUNT)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .opcode          (in_ch.opcode),
        .sample_word     (in_ch.sample_word),
        .track_select    (in_ch.track_select),
        .track_mode      (in_ch.track_mode),
        .track_muted     (in_ch.track_muted),
        .record_offset   (in_ch.record_offset),
        .recorded_length (in_ch.recorded_length),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    mal_back #(
        .TRACK_COUNT     (TRACK_COUNT),
        .CHUNK_LEN       (CHUNK_LEN),
        .MAX_LOOP_CHUNKS (MAX_LOOP_CHUNKS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .shared_off (shared_timeline_off_reg),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .mixed_word (out_ch.mixed_word),
        .chunk_end  (out_ch.chunk_end)
    );

endmodule

### hw/rtl/mal_checker.sv
// mal_checker: port-level assertions on the looper, bound to the top level
// depends on multitrack_audio_looper

module mal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // the mode register reads back what was written
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr == 3'd0
        |=> paddr != 3'd0 || prdata[0] == $past(pwdata[0]))
        else $error("mode register readback mismatch");

    a_cfg_upper: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:1] == 31'd0)
        else $error("unused register bits read nonzero");

endmodule

bind multitrack_audio_looper mal_checker u_mal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

### sim/tb.sv
// tb: self-checking testbench for multitrack_audio_looper, scoreboard class plus driver tasks
// depends on mal_pkg, mal_if and the multitrack_audio_looper rtl
`timescale 1ns / 100ps

module tb;
    import mal_pkg::*;

    localparam int TRACKS = 4;
    localparam int CHUNK = 64;
    localparam int LOOP_CHUNKS = 256;

    typedef struct {
        opcode_t      op;
        logic [31:0]  word;
        logic [1:0]   sel;
        track_state_t mode;
        logic         muted;
        logic [7:0]   offset;
        logic [8:0]   region;
    } loop_item_t;

    class looper_scoreboard;
        bit           timeline_free;
        track_state_t state[TRACKS];
        bit           mute[TRACKS];
        int           pos[TRACKS];
        int           len[TRACKS];
        int           offs[TRACKS];
        int           region[TRACKS];
        int           glen;
        int           gpos;
        int           sic;
        logic [31:0]  loop_mem[int];
        logic [32:0]  expected_mix[$];
        int           fails;
        int           mixes_checked;

        function new();
            timeline_free = 0;
            fails = 0;
            mixes_checked = 0;
            foreach (mute[t])
                mute[t] = 0;
            clear_tracks();
        endfunction

        function void clear_tracks();
            foreach (state[t])
            begin
                state[t] = TS_IDLE;
                pos[t] = 0;
                len[t] = 0;
                offs[t] = 0;
                region[t] = 0;
            end
            glen = 0;
            gpos = 0;
            sic = 0;
        endfunction

        function int play_pos(int t);
            int d;
            if (timeline_free || glen == 0)
                return pos[t];
            d = (gpos + glen - offs[t]) & 'h3FF;
            if (d >= glen)
                d -= glen;
            return d;
        endfunction

        function int mem_addr(int t, int p);
            return (t * LOOP_CHUNKS + p % LOOP_CHUNKS) * CHUNK + sic;
        endfunction

        function bit in_region(int t, int p);
            return region[t] == 0 || p < region[t];
        endfunction

        function logic [31:0] add24(logic [31:0] acc, logic [31:0] w);
            logic [31:0] s;
            s = (acc & AUDIO_MASK) + (w & AUDIO_MASK);
            return (acc & FRAME_MASK) | (s & AUDIO_MASK);
        endfunction

        // track whose next sample would read loop memory that was never written, else -1
        function int blank_track();
            int p;
            for (int t = 0; t < TRACKS; t++)
            begin
                if (state[t] == TS_DUB || state[t] == TS_MON)
                begin
                    p = play_pos(t);
                    if (in_region(t, p) && !loop_mem.exists(mem_addr(t, p)))
                        return t;
                end
            end
            return -1;
        endfunction

        function void advance();
            if (!timeline_free && glen > 0)
                gpos = (gpos + 1) % glen;
            for (int t = 0; t < TRACKS; t++)
            begin
                if (state[t] == TS_REC)
                begin
                    pos[t]++;
                    len[t] = pos[t];
                    if (!timeline_free && glen > 0 && pos[t] >= glen)
                    begin
                        len[t] = glen;
                        state[t] = TS_DUB;
                    end
                    else if (pos[t] >= LOOP_CHUNKS)
                    begin
                        if (!timeline_free && glen == 0)
                        begin
                            glen = len[t];
                            gpos = 0;
                        end
                        state[t] = TS_DUB;
                    end
                end
                else if (timeline_free && (state[t] == TS_DUB || state[t] == TS_MON))
                begin
                    if (len[t] > 0)
                        pos[t] = (pos[t] + 1) % len[t];
                end
            end
        endfunction

        function void note_item(loop_item_t it);
            logic [31:0] mix;
            logic [31:0] w;
            int          p;
            int          a;
            bit          seeded;
            bit          via_track;
            bit          ce;
            case (it.op)
                OP_CTRL:
                begin
                    state[it.sel] = it.mode;
                    mute[it.sel] = it.muted;
                    offs[it.sel] = int'(it.offset);
                    region[it.sel] = int'(it.region);
                end
                OP_CLEAR:
                    clear_tracks();
                OP_SAMPLE:
                begin
                    mix = '0;
                    seeded = 0;
                    via_track = 0;
                    for (int t = 0; t < TRACKS; t++)
                    begin
                        if (state[t] == TS_REC)
                            loop_mem[mem_addr(t, pos[t])] = it.word;
                        else if (state[t] == TS_DUB)
                        begin
                            p = play_pos(t);
                            if (in_region(t, p))
                            begin
                                a = mem_addr(t, p);
                                loop_mem[a] = add24(loop_mem[a], it.word);
                            end
                        end
                    end
                    for (int t = 0; t < TRACKS; t++)
                    begin
                        if (state[t] == TS_IDLE)
                            continue;
                        if (state[t] == TS_REC || state[t] == TS_DUB)
                            via_track = 1;
                        p = (state[t] == TS_REC) ? pos[t] : play_pos(t);
                        if (state[t] != TS_REC && !in_region(t, p))
                            continue;
                        w = loop_mem[mem_addr(t, p)];
                        if (!seeded)
                        begin
                            mix = mute[t] ? (w & FRAME_MASK) : w;
                            seeded = 1;
                        end
                        else if (!mute[t])
                            mix = add24(mix, w);
                    end
                    if (!seeded)
                        mix = it.word;
                    else if (!via_track)
                        mix = add24(mix, it.word);
                    ce = 0;
                    if (sic + 1 >= CHUNK)
                    begin
                        ce = 1;
                        sic = 0;
                        advance();
                    end
                    else
                        sic++;
                    expected_mix.push_back({ce, mix});
                end
                default:
                    ;
            endcase
        endfunction

        function void check_mix(logic [31:0] word, logic ce);
            logic [32:0] exp_res;
            if (expected_mix.size() == 0)
            begin
                $error("mix result with nothing expected: mixed_word %h", word);
                fails++;
                return;
            end
            exp_res = expected_mix.pop_front();
            mixes_checked++;
            if (word !== exp_res[31:0])
            begin
                $error("mixed_word expected %h actual %h", exp_res[31:0], word);
                fails++;
            end
            if (ce !== exp_res[32])
            begin
                $error("chunk_end expected %b actual %b", exp_res[32], ce);
                fails++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mal_in_if  in_ch ();
    mal_out_if out_ch ();

    looper_scoreboard sb;
    bit steady;
    bit hold_req;
    int items_sent;
    int cfg_writes;

    multitrack_audio_looper i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("timeout");
        $display("[multitrack_audio_looper] ERROR");
        $finish;
    end

    // result side: ready with random stalls and one long hold-off on request
    initial
    begin
        bit          fire;
        logic [31:0] word;
        logic        ce;
        int          hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            fire = out_ch.valid && out_ch.ready;
            word = out_ch.mixed_word;
            ce = out_ch.chunk_end;
            @(posedge clk);
            if (fire)
                sb.check_mix(word, ce);
            if (hold_req && hold == 0)
            begin
                hold = 400;
                hold_req = 0;
            end
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= steady || ($urandom_range(99) >= 9);
        end
    end

    task automatic write_timeline(bit free);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {31'd0, free};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.timeline_free = free;
        cfg_writes++;
    endtask

    task automatic send_item(loop_item_t it);
        bit ok;
        if (!steady && $urandom_range(99) < 9)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= it.op;
        in_ch.sample_word <= it.word;
        in_ch.track_select <= it.sel;
        in_ch.track_mode <= it.mode;
        in_ch.track_muted <= it.muted;
        in_ch.record_offset <= it.offset;
        in_ch.recorded_length <= it.region;
        do
        begin
            @(negedge clk);
            ok = in_ch.ready;
            @(posedge clk);
        end
        while (!ok);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_ctrl(int t, track_state_t m, bit mu, int off, int reg_len);
        loop_item_t it;
        it.op = OP_CTRL;
        it.word = $urandom;
        it.sel = 2'(t);
        it.mode = m;
        it.muted = mu;
        it.offset = 8'(off);
        it.region = 9'(reg_len);
        send_item(it);
    endtask

    task automatic send_simple(opcode_t op, logic [31:0] word);
        loop_item_t it;
        it.op = op;
        it.word = word;
        it.sel = 2'($urandom);
        it.mode = track_state_t'($urandom_range(3));
        it.muted = 1'($urandom);
        it.offset = 8'($urandom);
        it.region = 9'($urandom_range(256));
        send_item(it);
    endtask

    // parks any track that would play back memory never recorded
    task automatic send_sample(logic [31:0] word);
        int t;
        t = sb.blank_track();
        while (t >= 0)
        begin
            send_ctrl(t, TS_IDLE, 1'($urandom), $urandom, $urandom_range(256));
            t = sb.blank_track();
        end
        send_simple(OP_SAMPLE, word);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.expected_mix.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic run_loop_phase(int extra);
        int nrec;
        int chunks;
        int r;
        send_simple(OP_CLEAR, $urandom);
        nrec = $urandom_range(1, TRACKS);
        chunks = $urandom_range(1, 2);
        for (int t = 0; t < nrec; t++)
            send_ctrl(t, TS_REC, 1'($urandom), $urandom, $urandom_range(256));
        repeat (chunks * CHUNK) send_sample($urandom);
        for (int t = 0; t < nrec; t++)
            send_ctrl(t, ($urandom_range(1)) ? TS_DUB : TS_MON, $urandom_range(3) == 0,
                      $urandom, ($urandom_range(5) == 0) ? 0 : chunks);
        repeat (extra)
        begin
            r = $urandom_range(99);
            if (r < 85)
                send_sample($urandom);
            else if (r < 96)
                send_ctrl($urandom_range(3), track_state_t'($urandom_range(3)), 1'($urandom),
                          $urandom, ($urandom_range(3) == 0) ? 256 : $urandom_range(255));
            else if (r < 99)
                send_simple(OP_NONE, $urandom);
            else
                send_simple(OP_CLEAR, $urandom);
        end
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        steady = 1'b1;
        hold_req = 1'b0;
        items_sent = 0;
        cfg_writes = 0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.opcode <= OP_SAMPLE;
        in_ch.sample_word <= '0;
        in_ch.track_select <= '0;
        in_ch.track_mode <= TS_IDLE;
        in_ch.track_muted <= 1'b0;
        in_ch.record_offset <= '0;
        in_ch.recorded_length <= '0;
        out_ch.ready <= 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pass-through, ignored opcode, record extremes, mutes, clear
        write_timeline(1'b0);
        send_simple(OP_NONE, 32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_ctrl(0, TS_REC, 1'b0, 255, 256);
        send_ctrl(1, TS_REC, 1'b1, 0, 0);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'h0FFF_FFF0);
        send_ctrl(2, TS_MON, 1'b1, 128, 1);
        send_ctrl(3, TS_DUB, 1'b0, 1, 2);
        send_sample(32'hF000_000F);
        send_sample(32'h0000_0010);
        send_simple(OP_CLEAR, 32'h0);
        send_sample(32'hA5A5_A5A5);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_timeline(1'(ph % 2));
            steady = (ph == 1);
            if (ph == 3)
                hold_req = 1'b1;
            run_loop_phase(200);
            wait_drained();
        end
        steady = 1'b0;
        in_ch.valid <= 1'b0;

        wait_drained();
        $display("run sent %0d items and checked %0d mixed words", items_sent,
                 sb.mixes_checked);
        $display("timeline register written %0d times, both settings used", cfg_writes);
        if (sb.fails == 0 && sb.expected_mix.size() == 0)
            $display("[multitrack_audio_looper] OK");
        else
            $display("[multitrack_audio_looper] ERROR");
        $finish;
    end

endmodule
